/* sv/vfc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vfc_pkg: shared types and constants of the vehicle footprint block
// Types of the pose and outline words, register indexes, the CORDIC arctangent
// table and the rounding helpers used by the pipeline.
// ----------------------------------------------------------------------------
package vfc_pkg;

    // default configuration of the block
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ANGLE_BITS_DEF    = 16;

    // field widths
    localparam int COORD_W = 32;
    localparam int DIM_W   = 24;
    localparam int HEAD_W  = 16;
    localparam int VEC_W   = 33;   // cordic x and y, Q30 with headroom
    localparam int TRIG_W  = 17;   // folded cosine and sine, Q1.15 plus sign room
    localparam int PROD_W  = 42;   // trig times dimension
    localparam int PT_W    = 52;   // corner coordinate in 2^-33 units

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_CAR_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAR_WIDTH  = 1'd1;

    localparam logic [DIM_W-1:0] CAR_LENGTH_RST = 24'd262144;
    localparam logic [DIM_W-1:0] CAR_WIDTH_RST  = 24'd131072;

    // corner codes
    localparam logic [1:0] IDX_TAIL_LEFT  = 2'd0;
    localparam logic [1:0] IDX_TAIL_RIGHT = 2'd1;
    localparam logic [1:0] IDX_HEAD_RIGHT = 2'd2;
    localparam logic [1:0] IDX_HEAD_LEFT  = 2'd3;

    // point counter codes, the closing point repeats the tail left corner
    localparam logic [2:0] PT_FIRST = 3'd0;
    localparam logic [2:0] PT_CLOSE = 3'd4;

    // start vector, 1/K in Q30
    localparam logic signed [VEC_W-1:0] INV_GAIN_Q30 = 33'sd652032875;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURN32 [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic [1:0]                quad;
    } vfc_pose_t;

    typedef struct packed {
        logic [3:0][COORD_W-1:0] cx;
        logic [3:0][COORD_W-1:0] cy;
    } vfc_outline_t;

    // rounded arctangent step for one stage at a given angle resolution
    function automatic logic [31:0] atan_step(input int stage, input int abits);
        logic [32:0] tmp;
        int          sh;
        sh  = 32 - abits;
        tmp = {1'b0, ATAN_TURN32[stage]} + (33'd1 << (sh - 1));
        return 32'(tmp >> sh);
    endfunction

    // round half up from 2^-33 to Q16.16 and clamp to 32 bits
    function automatic logic [COORD_W-1:0] round_sat(input logic signed [PT_W-1:0] v);
        logic signed [PT_W-1:0] r;
        r = (v + PT_W'(65536)) >>> 17;
        if (r > PT_W'(64'sd2147483647)) begin
            return 32'h7fff_ffff;
        end else if (r < -PT_W'(64'sd2147483648)) begin
            return 32'h8000_0000;
        end else begin
            return r[COORD_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

/* sv/vehicle_footprint_corners.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vehicle_footprint_corners: outline of a vehicle footprint from its pose
// Pose in, five outline points out: tail left, tail right, head right,
// head left and tail left again.
// ----------------------------------------------------------------------------
// A pose word passes a chain of CORDIC_STAGES rotation cells and four corner
// stages and then the serialiser's outline register before its first point
// appears. Each pose yields five point words on the output channel, one per
// cycle while m_ready is high, and the output channel sets the sustained
// pose rate. Poses can be sent back to back; the whole chain holds while the
// point serialiser still has a pose to send and the next one is ready.
// car_length and car_width are to be written through cfg_we only while no
// pose is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module vehicle_footprint_corners #(
    parameter int CORDIC_STAGES = vfc_pkg::CORDIC_STAGES_DEF,
    parameter int ANGLE_BITS    = vfc_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [vfc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [vfc_pkg::DIM_W-1:0]         cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [vfc_pkg::COORD_W-1:0] s_pos_x,
    input  wire logic signed [vfc_pkg::COORD_W-1:0] s_pos_y,
    input  wire logic [vfc_pkg::HEAD_W-1:0]        s_heading,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [vfc_pkg::COORD_W-1:0]     m_corner_x,
    output logic signed [vfc_pkg::COORD_W-1:0]     m_corner_y,
    output logic [1:0]                             m_corner_index,
    output logic                                   m_last_point
);
    import vfc_pkg::*;

    localparam int ZW = ANGLE_BITS + 1;

    logic [DIM_W-1:0] car_length_reg, car_width_reg;

    logic                    v_chain [0:CORDIC_STAGES];
    logic signed [VEC_W-1:0] x_chain [0:CORDIC_STAGES];
    logic signed [VEC_W-1:0] y_chain [0:CORDIC_STAGES];
    logic signed [ZW-1:0]    z_chain [0:CORDIC_STAGES];
    vfc_pose_t               p_chain [0:CORDIC_STAGES];

    logic [31:0]           turn;
    logic [ANGLE_BITS-1:0] ang;
    logic                  en;
    logic                  calc_valid;
    vfc_outline_t          calc_outline;
    logic                  ser_can_load;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            car_length_reg <= CAR_LENGTH_RST;
            car_width_reg  <= CAR_WIDTH_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CAR_LENGTH: car_length_reg <= cfg_wdata;
                REG_CAR_WIDTH:  car_width_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // chain moves whenever its last word can be handed on
    assign en      = !calc_valid || ser_can_load;
    assign s_ready = en;

    // heading to quadrant and residual angle
    assign turn = {s_heading, 16'd0};
    assign ang  = turn[31 -: ANGLE_BITS];

    assign v_chain[0]      = s_valid;
    assign x_chain[0]      = INV_GAIN_Q30;
    assign y_chain[0]      = '0;
    assign z_chain[0]      = {3'b000, ang[ANGLE_BITS-3:0]};
    assign p_chain[0].px   = s_pos_x;
    assign p_chain[0].py   = s_pos_y;
    assign p_chain[0].quad = ang[ANGLE_BITS-1 -: 2];

    // rotation cells
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
        vfc_cordic_cell #(
            .STAGE      (i),
            .ANGLE_BITS (ANGLE_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (v_chain[i]),
            .in_x      (x_chain[i]),
            .in_y      (y_chain[i]),
            .in_z      (z_chain[i]),
            .in_pose   (p_chain[i]),
            .out_valid (v_chain[i+1]),
            .out_x     (x_chain[i+1]),
            .out_y     (y_chain[i+1]),
            .out_z     (z_chain[i+1]),
            .out_pose  (p_chain[i+1])
        );
    end

    // corner arithmetic
    vfc_corner_calc u_calc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (v_chain[CORDIC_STAGES]),
        .in_x        (x_chain[CORDIC_STAGES]),
        .in_y        (y_chain[CORDIC_STAGES]),
        .in_pose     (p_chain[CORDIC_STAGES]),
        .car_length  (car_length_reg),
        .car_width   (car_width_reg),
        .out_valid   (calc_valid),
        .out_outline (calc_outline)
    );

    // point words out
    vfc_outline_ser u_ser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load_valid     (calc_valid),
        .load_outline   (calc_outline),
        .can_load       (ser_can_load),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_corner_x     (m_corner_x),
        .m_corner_y     (m_corner_y),
        .m_corner_index (m_corner_index),
        .m_last_point   (m_last_point)
    );

    // the residual angle left by the last cell is not used
    logic z_last_unused;
    assign z_last_unused = ^z_chain[CORDIC_STAGES];

    // input stalls only behind an outline still being sent
    a_stall_needs_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no outline pending");

    // the closing point repeats the tail left corner
    a_close_is_tail_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_point) |-> (m_corner_index == IDX_TAIL_LEFT))
        else $error("closing point is not tail left");

    // within an outline the points follow in order with no gap
    a_point_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_point) |=> (m_valid &&
        ((!m_last_point && (m_corner_index == $past(m_corner_index) + 2'd1)) ||
         (m_last_point && ($past(m_corner_index) == IDX_HEAD_LEFT)))))
        else $error("outline point out of order");

    // after the closing point a new outline starts at tail left
    a_new_outline: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_point) |=>
        (!m_valid || (!m_last_point && (m_corner_index == IDX_TAIL_LEFT))))
        else $error("outline does not start at tail left");

endmodule
`default_nettype wire

/* sv/vfc_cordic_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vfc_cordic_cell: one rotation stage of the cosine and sine chain
// Rotates the vector by plus or minus atan(2^-STAGE) towards a zero residual
// angle and passes the pose word along with it.
// ----------------------------------------------------------------------------
module vfc_cordic_cell #(
    parameter int STAGE      = 0,
    parameter int ANGLE_BITS = vfc_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              en,
    input  wire logic                              in_valid,
    input  wire logic signed [vfc_pkg::VEC_W-1:0]  in_x,
    input  wire logic signed [vfc_pkg::VEC_W-1:0]  in_y,
    input  wire logic signed [ANGLE_BITS:0]        in_z,
    input  wire vfc_pkg::vfc_pose_t                in_pose,
    output logic                                   out_valid,
    output logic signed [vfc_pkg::VEC_W-1:0]       out_x,
    output logic signed [vfc_pkg::VEC_W-1:0]       out_y,
    output logic signed [ANGLE_BITS:0]             out_z,
    output vfc_pkg::vfc_pose_t                     out_pose
);
    import vfc_pkg::*;

    localparam int ZW = ANGLE_BITS + 1;
    localparam logic signed [ZW-1:0] STEP = ZW'(atan_step(STAGE, ANGLE_BITS));

    logic                    valid_reg;
    logic signed [VEC_W-1:0] x_reg, x_next;
    logic signed [VEC_W-1:0] y_reg, y_next;
    logic signed [ZW-1:0]    z_reg, z_next;
    vfc_pose_t               pose_reg;
    logic signed [VEC_W-1:0] dx, dy;

    // one micro-rotation
    always_comb begin
        dx = in_y >>> STAGE;
        dy = in_x >>> STAGE;
        if (!in_z[ZW-1]) begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - STEP;
        end else begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + STEP;
        end
    end

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // vector and pose word
    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            pose_reg <= in_pose;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_pose  = pose_reg;

endmodule
`default_nettype wire

/* sv/vfc_corner_calc.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vfc_corner_calc: cosine and sine to the four footprint corners
// Four stages: round and quadrant fold, dimension products, tail and head
// centres, then the corners rounded and clamped to Q16.16.
// ----------------------------------------------------------------------------
module vfc_corner_calc (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              en,
    input  wire logic                              in_valid,
    input  wire logic signed [vfc_pkg::VEC_W-1:0]  in_x,
    input  wire logic signed [vfc_pkg::VEC_W-1:0]  in_y,
    input  wire vfc_pkg::vfc_pose_t                in_pose,
    input  wire logic [vfc_pkg::DIM_W-1:0]         car_length,
    input  wire logic [vfc_pkg::DIM_W-1:0]         car_width,
    output logic                                   out_valid,
    output vfc_pkg::vfc_outline_t                  out_outline
);
    import vfc_pkg::*;

    // Q30 to Q1.15, round half up, clamp to 16 bits
    function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [VEC_W-1:0] v);
        logic signed [VEC_W-1:0] r;
        r = (v + VEC_W'(16384)) >>> 15;
        if (r > VEC_W'(32767)) begin
            return TRIG_W'(32767);
        end else if (r < -VEC_W'(32768)) begin
            return -TRIG_W'(32768);
        end else begin
            return r[TRIG_W-1:0];
        end
    endfunction

    logic [3:0] valid_reg;

    logic signed [TRIG_W-1:0]  c_reg, c_next, s_reg, s_next;
    logic signed [COORD_W-1:0] fpx_reg, fpy_reg;
    logic signed [TRIG_W-1:0]  c_raw, s_raw;

    logic signed [PROD_W-1:0]  cl_reg, sl_reg, cw_reg, sw_reg;
    logic signed [COORD_W-1:0] mpx_reg, mpy_reg;

    logic signed [PT_W-1:0]    tx_reg, ty_reg, hx_reg, hy_reg, sw2_reg, cw2_reg;
    logic signed [PT_W-1:0]    tx_next, ty_next, hx_next, hy_next;
    logic signed [PT_W-1:0]    pxs, pys, cl_w, sl_w;

    vfc_outline_t              outline_reg, outline_next;

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    // round and quadrant fold
    always_comb begin
        c_raw = to_q15(in_x);
        s_raw = to_q15(in_y);
        unique case (in_pose.quad)
            2'd0: begin c_next = c_raw;  s_next = s_raw;  end
            2'd1: begin c_next = -s_raw; s_next = c_raw;  end
            2'd2: begin c_next = -c_raw; s_next = -s_raw; end
            2'd3: begin c_next = s_raw;  s_next = -c_raw; end
            default: begin c_next = c_raw; s_next = s_raw; end
        endcase
    end

    // tail and head centres
    always_comb begin
        pxs     = {{(PT_W-COORD_W-17){mpx_reg[COORD_W-1]}}, mpx_reg, 17'd0};
        pys     = {{(PT_W-COORD_W-17){mpy_reg[COORD_W-1]}}, mpy_reg, 17'd0};
        cl_w    = PT_W'(cl_reg);
        sl_w    = PT_W'(sl_reg);
        tx_next = pxs - cl_w;
        ty_next = pys - sl_w;
        hx_next = pxs + cl_w + (cl_w <<< 1);
        hy_next = pys + sl_w + (sl_w <<< 1);
    end

    // corners, rounded and clamped
    always_comb begin
        outline_next.cx[0] = round_sat(tx_reg - sw2_reg);
        outline_next.cy[0] = round_sat(ty_reg + cw2_reg);
        outline_next.cx[1] = round_sat(tx_reg + sw2_reg);
        outline_next.cy[1] = round_sat(ty_reg - cw2_reg);
        outline_next.cx[2] = round_sat(hx_reg + sw2_reg);
        outline_next.cy[2] = round_sat(hy_reg - cw2_reg);
        outline_next.cx[3] = round_sat(hx_reg - sw2_reg);
        outline_next.cy[3] = round_sat(hy_reg + cw2_reg);
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg       <= c_next;
            s_reg       <= s_next;
            fpx_reg     <= in_pose.px;
            fpy_reg     <= in_pose.py;
            cl_reg      <= c_reg * $signed({1'b0, car_length});
            sl_reg      <= s_reg * $signed({1'b0, car_length});
            cw_reg      <= c_reg * $signed({1'b0, car_width});
            sw_reg      <= s_reg * $signed({1'b0, car_width});
            mpx_reg     <= fpx_reg;
            mpy_reg     <= fpy_reg;
            tx_reg      <= tx_next;
            ty_reg      <= ty_next;
            hx_reg      <= hx_next;
            hy_reg      <= hy_next;
            sw2_reg     <= PT_W'(sw_reg) <<< 1;
            cw2_reg     <= PT_W'(cw_reg) <<< 1;
            outline_reg <= outline_next;
        end
    end

    assign out_valid   = valid_reg[3];
    assign out_outline = outline_reg;

endmodule
`default_nettype wire

/* sv/vfc_outline_ser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vfc_outline_ser: outline to point words
// Holds one outline and sends its five points, the closing one repeating the
// tail left corner.
// ----------------------------------------------------------------------------
module vfc_outline_ser (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          load_valid,
    input  wire vfc_pkg::vfc_outline_t         load_outline,
    output logic                               can_load,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [vfc_pkg::COORD_W-1:0]        m_corner_x,
    output logic [vfc_pkg::COORD_W-1:0]        m_corner_y,
    output logic [1:0]                         m_corner_index,
    output logic                               m_last_point
);
    import vfc_pkg::*;

    logic         busy_reg, busy_next;
    logic [2:0]   count_reg, count_next;
    vfc_outline_t outline_reg;
    logic         take, last;
    logic [1:0]   idx;

    assign last     = (count_reg == PT_CLOSE);
    assign take     = busy_reg && m_ready;
    assign can_load = !busy_reg || (take && last);

    // point counter
    always_comb begin
        busy_next  = busy_reg;
        count_next = count_reg;
        if (load_valid && can_load) begin
            busy_next  = 1'b1;
            count_next = PT_FIRST;
        end else if (take) begin
            if (last) begin
                busy_next = 1'b0;
            end else begin
                count_next = count_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= PT_FIRST;
        end else begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    // outline store
    always_ff @(posedge aclk) begin
        if (load_valid && can_load) begin
            outline_reg <= load_outline;
        end
    end

    // point select
    assign idx            = last ? IDX_TAIL_LEFT : count_reg[1:0];
    assign m_valid        = busy_reg;
    assign m_corner_x     = outline_reg.cx[idx];
    assign m_corner_y     = outline_reg.cy[idx];
    assign m_corner_index = idx;
    assign m_last_point   = last;

endmodule
`default_nettype wire

/* tb/sv/vehicle_footprint_corners_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vehicle_footprint_corners_tb: self-checking bench of the footprint block
// Drives poses through the valid/ready input, rebuilds each outline with a
// bit-exact CORDIC and corner predictor, and checks every point word in
// order. A directed table comes first, then random phases with new car
// dimensions and different amounts of idling on both sides.
// ----------------------------------------------------------------------------
module vehicle_footprint_corners_tb;

    localparam int N_STAGES    = vfc_pkg::CORDIC_STAGES_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_SHOWN   = 40;
    localparam int N_PHASES    = 8;
    localparam int PHASE_POSES = 24;
    localparam int N_DIRECTED  = 25;

    localparam logic [23:0] DIM_MAX   = 24'hff_ffff;
    localparam logic [23:0] LEN_RST   = vfc_pkg::CAR_LENGTH_RST;
    localparam logic [23:0] WID_RST   = vfc_pkg::CAR_WIDTH_RST;
    localparam longint      Q16_MAX   = 64'sd2147483647;
    localparam longint      Q16_MIN   = -64'sd2147483648;
    localparam longint      START_VEC = 64'sd652032875;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [0:15][31:0] ATAN_TBL = {
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861
    };

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [1:0]  idx;
        logic        last;
    } outline_pt_t;

    typedef struct packed {
        logic [23:0] len;
        logic [23:0] wid;
        logic [31:0] px;
        logic [31:0] py;
        logic [15:0] hd;
        logic        pinned;   // zero-size car: every point is the pose itself
    } pose_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [vfc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [23:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic signed [31:0] s_pos_x;
    logic signed [31:0] s_pos_y;
    logic [15:0] s_heading;
    logic        m_valid;
    logic        m_ready;
    logic signed [31:0] m_corner_x;
    logic signed [31:0] m_corner_y;
    logic [1:0]  m_corner_index;
    logic        m_last_point;

    outline_pt_t pending_pts[$];
    pose_row_t   pose_tbl [N_DIRECTED];
    logic [23:0] dim_len;
    logic [23:0] dim_wid;
    int          src_idle_pct;
    int          snk_stall_pct;
    int          n_errors;
    int          n_points;
    int          cycle_cnt;

    vehicle_footprint_corners u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_heading      (s_heading),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_corner_x     (m_corner_x),
        .m_corner_y     (m_corner_y),
        .m_corner_index (m_corner_index),
        .m_last_point   (m_last_point)
    );

    // clock
    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // ---------------------------------------------------------------- predictor

    function automatic longint clip_q15(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // cosine and sine of the heading in Q1.15, quadrant folded
    function automatic void heading_trig(input logic [15:0] hd, output longint c,
                                         output longint s);
        longint x, y, z, dx, dy, step, cr, sr;
        int     i;
        x = START_VEC;
        y = 0;
        z = longint'(hd[13:0]);
        for (i = 0; i < N_STAGES; i++) begin
            step = (longint'(ATAN_TBL[i]) + 32768) >>> 16;
            dx   = y >>> i;
            dy   = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - step;
            end else begin
                x = x + dx; y = y - dy; z = z + step;
            end
        end
        cr = clip_q15((x + 16384) >>> 15);
        sr = clip_q15((y + 16384) >>> 15);
        case (hd[15:14])
            2'd0: begin c = cr;  s = sr;  end
            2'd1: begin c = -sr; s = cr;  end
            2'd2: begin c = -cr; s = -sr; end
            default: begin c = sr; s = -cr; end
        endcase
    endfunction

    // 2^-33 units to Q16.16, half up, clamped
    function automatic logic [31:0] to_q16(input longint v);
        longint r;
        r = (v + 65536) >>> 17;
        if (r > Q16_MAX) r = Q16_MAX;
        else if (r < Q16_MIN) r = Q16_MIN;
        return 32'(r);
    endfunction

    // four corners in, five point words queued, the last one closing the loop
    function automatic void queue_outline(input logic [3:0][31:0] xs,
                                          input logic [3:0][31:0] ys);
        outline_pt_t pt;
        int          k;
        for (k = 0; k < 5; k++) begin
            pt.idx  = (k == 4) ? vfc_pkg::IDX_TAIL_LEFT : 2'(k);
            pt.x    = xs[pt.idx];
            pt.y    = ys[pt.idx];
            pt.last = (k == 4);
            pending_pts.insert(pending_pts.size(), pt);
        end
    endfunction

    function automatic void predict_outline(input logic [31:0] px, py,
                                            input logic [15:0] hd);
        longint c, s, cl, sl, cw, sw, tx, ty, hx, hy;
        logic [3:0][31:0] xs, ys;
        heading_trig(hd, c, s);
        cl = c * longint'(dim_len);
        sl = s * longint'(dim_len);
        cw = 2 * c * longint'(dim_wid);
        sw = 2 * s * longint'(dim_wid);
        tx = longint'(signed'(px)) * 131072 - cl;
        ty = longint'(signed'(py)) * 131072 - sl;
        hx = longint'(signed'(px)) * 131072 + 3 * cl;
        hy = longint'(signed'(py)) * 131072 + 3 * sl;
        xs[vfc_pkg::IDX_TAIL_LEFT]  = to_q16(tx - sw);
        ys[vfc_pkg::IDX_TAIL_LEFT]  = to_q16(ty + cw);
        xs[vfc_pkg::IDX_TAIL_RIGHT] = to_q16(tx + sw);
        ys[vfc_pkg::IDX_TAIL_RIGHT] = to_q16(ty - cw);
        xs[vfc_pkg::IDX_HEAD_RIGHT] = to_q16(hx + sw);
        ys[vfc_pkg::IDX_HEAD_RIGHT] = to_q16(hy - cw);
        xs[vfc_pkg::IDX_HEAD_LEFT]  = to_q16(hx - sw);
        ys[vfc_pkg::IDX_HEAD_LEFT]  = to_q16(hy + cw);
        queue_outline(xs, ys);
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic flag_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        n_errors++;
        if (n_errors <= MAX_SHOWN)
            $display("point %0d: %s expected %h got %h", n_points, field, want, got);
    endtask

    task automatic check_point();
        outline_pt_t want;
        n_points++;
        if (pending_pts.size() == 0) begin
            flag_mismatch("word without pose, x", 32'd0, m_corner_x);
        end else begin
            want = pending_pts.pop_front();
            if (m_corner_x !== want.x)
                flag_mismatch("corner_x", want.x, m_corner_x);
            if (m_corner_y !== want.y)
                flag_mismatch("corner_y", want.y, m_corner_y);
            if (m_corner_index !== want.idx)
                flag_mismatch("corner_index", 32'(want.idx), 32'(m_corner_index));
            if (m_last_point !== want.last)
                flag_mismatch("last_point", 32'(want.last), 32'(m_last_point));
        end
    endtask

    // output side: take point words, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            check_point();
        m_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("** vehicle_footprint_corners: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic send_pose(input logic [31:0] px, py, input logic [15:0] hd,
                             input logic pinned);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_pos_x   <= px;
        s_pos_y   <= py;
        s_heading <= hd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (pinned)
            queue_outline({4{px}}, {4{py}});
        else
            predict_outline(px, py, hd);
    endtask

    // drop valid and let every outstanding point word come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_pts.size() != 0) @(posedge aclk);
    endtask

    task automatic set_dims(input logic [23:0] len, wid);
        cfg_we    <= 1'b1;
        cfg_index <= vfc_pkg::REG_CAR_LENGTH;
        cfg_wdata <= len;
        @(posedge aclk);
        cfg_index <= vfc_pkg::REG_CAR_WIDTH;
        cfg_wdata <= wid;
        @(posedge aclk);
        cfg_we  <= 1'b0;
        dim_len = len;
        dim_wid = wid;
    endtask

    function automatic void set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SRC:  begin src_idle_pct = 66; snk_stall_pct = 0;  end
            IDLE_SNK:  begin src_idle_pct = 0;  snk_stall_pct = 66; end
            IDLE_BOTH: begin src_idle_pct = 7;  snk_stall_pct = 7;  end
            default:   begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        endcase
    endfunction

    // mostly plausible positions, some full range and some near the rails
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            6, 7:    return $urandom;
            8:       return 32'h7fff_ffff - $urandom_range(0, 4096);
            9:       return 32'h8000_0000 + $urandom_range(0, 4096);
            default: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
        endcase
    endfunction

    // quarter-turn boundaries get extra weight
    function automatic logic [15:0] rand_heading();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom_range(0, 3) << 14) + 16'($urandom_range(0, 2)) - 16'd1;
        return 16'($urandom_range(0, 65535));
    endfunction

    initial begin
        int p;
        int n;
        int r;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = vfc_pkg::REG_CAR_LENGTH;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_pos_x       = '0;
        s_pos_y       = '0;
        s_heading     = '0;
        m_ready       = 1'b0;
        dim_len       = LEN_RST;
        dim_wid       = WID_RST;
        n_errors      = 0;
        n_points      = 0;
        cycle_cnt     = 0;
        set_idling(IDLE_NONE);

        // directed poses: quadrants, rails, zero, largest and smallest car
        pose_tbl = '{
            '{LEN_RST, WID_RST, 32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b0},
            '{LEN_RST, WID_RST, 32'h0000_0000, 32'h0000_0000, 16'h4000, 1'b0},
            '{LEN_RST, WID_RST, 32'h0000_0000, 32'h0000_0000, 16'h8000, 1'b0},
            '{LEN_RST, WID_RST, 32'h0000_0000, 32'h0000_0000, 16'hc000, 1'b0},
            '{LEN_RST, WID_RST, 32'h0000_0000, 32'h0000_0000, 16'hffff, 1'b0},
            '{LEN_RST, WID_RST, 32'h0000_0000, 32'h0000_0000, 16'h2000, 1'b0},
            '{LEN_RST, WID_RST, 32'h7fff_ffff, 32'h7fff_ffff, 16'h0000, 1'b0},
            '{LEN_RST, WID_RST, 32'h8000_0000, 32'h8000_0000, 16'h8000, 1'b0},
            '{LEN_RST, WID_RST, 32'h7fff_ffff, 32'h8000_0000, 16'h4000, 1'b0},
            '{LEN_RST, WID_RST, 32'h8000_0000, 32'h7fff_ffff, 16'hc000, 1'b0},
            '{24'd0,   24'd0,   32'h7fff_ffff, 32'h8000_0000, 16'h1234, 1'b1},
            '{24'd0,   24'd0,   32'h8000_0000, 32'h7fff_ffff, 16'hffff, 1'b1},
            '{24'd0,   24'd0,   32'h0000_0000, 32'h0000_0000, 16'haaaa, 1'b1},
            '{24'd0,   24'd0,   32'h5555_aaaa, 32'haaaa_5555, 16'h5555, 1'b1},
            '{DIM_MAX, DIM_MAX, 32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b0},
            '{DIM_MAX, DIM_MAX, 32'h0000_0000, 32'h0000_0000, 16'h2000, 1'b0},
            '{DIM_MAX, DIM_MAX, 32'h7fff_ffff, 32'h0000_0000, 16'h4000, 1'b0},
            '{DIM_MAX, DIM_MAX, 32'h0000_0000, 32'h8000_0000, 16'hc000, 1'b0},
            '{DIM_MAX, DIM_MAX, 32'h1234_5678, 32'h9abc_def0, 16'hffff, 1'b0},
            '{DIM_MAX, 24'd0,   32'h0000_0000, 32'h0000_0000, 16'h1000, 1'b0},
            '{DIM_MAX, 24'd0,   32'h8000_0000, 32'h0000_0000, 16'h8000, 1'b0},
            '{24'd0,   DIM_MAX, 32'h0000_0000, 32'h0000_0000, 16'h3000, 1'b0},
            '{24'd0,   DIM_MAX, 32'h0000_0000, 32'h7fff_ffff, 16'h4000, 1'b0},
            '{24'd1,   24'd1,   32'h0000_0000, 32'h0000_0000, 16'h0001, 1'b0},
            '{24'd1,   24'd1,   32'hffff_ffff, 32'hffff_ffff, 16'he000, 1'b0}
        };

        // reset
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table, dimensions change only between groups
        for (r = 0; r < N_DIRECTED; r++) begin
            if (pose_tbl[r].len != dim_len || pose_tbl[r].wid != dim_wid) begin
                wait_idle();
                set_dims(pose_tbl[r].len, pose_tbl[r].wid);
            end
            send_pose(pose_tbl[r].px, pose_tbl[r].py, pose_tbl[r].hd, pose_tbl[r].pinned);
        end

        // random phases, each with its own car and idling pattern
        for (p = 0; p < N_PHASES; p++) begin
            wait_idle();
            case (p == 0 ? 4 : p == 1 ? 2 : $urandom_range(0, 5))
                0:       set_dims(LEN_RST, WID_RST);
                1:       set_dims(24'd0, 24'd0);
                2:       set_dims(DIM_MAX, DIM_MAX);
                3:       set_dims(24'($urandom), 24'($urandom));
                default: set_dims(24'($urandom_range(65536, 6 * 65536)),
                                  24'($urandom_range(32768, 3 * 65536)));
            endcase
            set_idling(idle_mode_t'(p % 4));
            for (n = 0; n < PHASE_POSES; n++)
                send_pose(rand_coord(), rand_coord(), rand_heading(), 1'b0);
        end

        // drain, then watch for stray words
        wait_idle();
        repeat (2 * N_STAGES + 16) @(posedge aclk);
        if (n_errors == 0) begin
            $display("** vehicle_footprint_corners: PASSED **");
        end else begin
            $display("** vehicle_footprint_corners: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* vehicle_footprint_corners.f */
sv/vfc_pkg.sv
sv/vfc_cordic_cell.sv
sv/vfc_corner_calc.sv
sv/vfc_outline_ser.sv
sv/vehicle_footprint_corners.sv
tb/sv/vehicle_footprint_corners_tb.sv
